// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CNMP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true out of reset
`define CNMP_NEVER(label, cond, msg) \
	`CNMP_ASSERT(label, !(cond), msg)

`endif

// ----- src/cnmp_pkg.sv -----
// ---------------------------------------------------------------------------
// Catalan number modulo prime: package
// Widths, constants, datapath select codes and controller types.
// ---------------------------------------------------------------------------
package cnmp_pkg;

	localparam int COUNT_WIDTH = 17;
	localparam int IDX_W       = COUNT_WIDTH + 1;
	localparam int VAL_W       = 30;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int RED_W       = VAL_W + 2;

	localparam logic [VAL_W-1:0] PRIME = VAL_W'(1000000009);

	// Barrett reduction: q1 = x >> (VAL_W-1), q = (q1 * MU) >> (VAL_W+1)
	localparam int Q1_W = PROD_W - (VAL_W - 1);
	localparam int MU_W = VAL_W + 1;
	localparam int QM_W = Q1_W + MU_W;
	localparam int Q_W  = QM_W - (VAL_W + 1);
	localparam logic [MU_W-1:0] BARRETT_MU =
		MU_W'((64'd1 << PROD_W) / 64'(PRIME));

	localparam logic [RED_W-1:0] PRIME_RED = RED_W'(PRIME);
	localparam logic [RED_W-1:0] TWO_PRIME = RED_W'(2) * RED_W'(PRIME);
	localparam logic [RED_W-1:0] THREE_PRIME = RED_W'(3) * RED_W'(PRIME);

	localparam int MUL_LATENCY = 5;
	localparam int RING_DEPTH  = MUL_LATENCY + 1;
	localparam int SLOT_W      = $clog2(RING_DEPTH);

	localparam int EXP_BITS = VAL_W;
	localparam int BIT_W    = $clog2(EXP_BITS);
	localparam logic [EXP_BITS-1:0] EXP_VAL = EXP_BITS'(PRIME - VAL_W'(2));

	typedef enum logic {
		LO_TWO,
		LO_NP2
	} lo_sel_t;

	typedef enum logic {
		HI_N,
		HI_2N
	} hi_sel_t;

	typedef enum logic {
		PH_LOW,
		PH_HIGH
	} phase_t;

	typedef enum logic [2:0] {
		A_ONE,
		A_RING,
		A_ACC,
		A_FN1,
		A_BASE
	} a_sel_t;

	typedef enum logic [2:0] {
		B_IDX,
		B_NP1,
		B_RING,
		B_ACC,
		B_X1,
		B_BASE,
		B_F
	} b_sel_t;

	typedef enum logic [2:0] {
		D_RING,
		D_ACC,
		D_FN1,
		D_F,
		D_BASE,
		D_OUT
	} dest_t;

	typedef struct packed {
		dest_t             dest;
		logic [SLOT_W-1:0] slot;
	} tag_t;

	typedef struct packed {
		logic              load_count;
		logic              stream_start;
		lo_sel_t           lo_sel;
		hi_sel_t           hi_sel;
		logic              idx_inc;
		logic              issue;
		a_sel_t            a_sel;
		b_sel_t            b_sel;
		dest_t             dest;
		logic [SLOT_W-1:0] slot;
		logic              x1_load;
		logic              acc_init;
	} cmd_t;

	typedef struct packed {
		logic idx_le_hi;
		logic pipe_empty;
		logic out_busy;
	} sts_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_STREAM,
		ST_COMBINE,
		ST_FN1,
		ST_FMUL,
		ST_DMUL,
		ST_POW_MUL,
		ST_POW_SQ,
		ST_FINAL,
		ST_WAIT
	} state_t;

endpackage

// ----- src/cnmp_mulmod.sv -----
// ---------------------------------------------------------------------------
// Modular multiplier
// Five-stage a*b mod PRIME: product, Barrett quotient, quotient*PRIME,
// subtract, final correction. A tag rides along with each operation.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cnmp_mulmod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [cnmp_pkg::VAL_W-1:0]   a,
	input  logic [cnmp_pkg::VAL_W-1:0]   b,
	input  cnmp_pkg::tag_t               in_tag,
	output logic                         out_vld,
	output logic [cnmp_pkg::VAL_W-1:0]   out_val,
	output cnmp_pkg::tag_t               out_tag,
	output logic                         busy
);

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	cnmp_pkg::tag_t                tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [cnmp_pkg::PROD_W-1:0]   prod_s1;
	logic [cnmp_pkg::RED_W-1:0]    x_s2, x_s3;
	logic [cnmp_pkg::QM_W-1:0]     qm_s2;
	logic [cnmp_pkg::RED_W-1:0]    m_s3;
	logic [cnmp_pkg::RED_W-1:0]    r_s4;
	logic [cnmp_pkg::VAL_W-1:0]    res_s5;

	logic [cnmp_pkg::Q1_W-1:0]     q1;
	logic [cnmp_pkg::Q_W-1:0]      q3;
	logic [cnmp_pkg::Q_W+cnmp_pkg::VAL_W-1:0] m_full;
	logic [cnmp_pkg::RED_W-1:0]    r_sub1, r_sub2, r_red;

	assign q1     = prod_s1[cnmp_pkg::PROD_W-1 -: cnmp_pkg::Q1_W];
	assign q3     = qm_s2[cnmp_pkg::QM_W-1 -: cnmp_pkg::Q_W];
	assign m_full = q3 * cnmp_pkg::PRIME;
	assign r_sub1 = r_s4 - cnmp_pkg::PRIME_RED;
	assign r_sub2 = r_s4 - cnmp_pkg::TWO_PRIME;

	always_comb begin
		if (r_s4 >= cnmp_pkg::TWO_PRIME) begin
			r_red = r_sub2;
		end else if (r_s4 >= cnmp_pkg::PRIME_RED) begin
			r_red = r_sub1;
		end else begin
			r_red = r_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		prod_s1 <= a * b;
		tag_s2  <= tag_s1;
		x_s2    <= prod_s1[cnmp_pkg::RED_W-1:0];
		qm_s2   <= q1 * cnmp_pkg::BARRETT_MU;
		tag_s3  <= tag_s2;
		x_s3    <= x_s2;
		m_s3    <= m_full[cnmp_pkg::RED_W-1:0];
		tag_s4  <= tag_s3;
		r_s4    <= x_s3 - m_s3;
		tag_s5  <= tag_s4;
		res_s5  <= r_red[cnmp_pkg::VAL_W-1:0];
	end

	assign out_vld = vld_s5;
	assign out_val = res_s5;
	assign out_tag = tag_s5;
	assign busy    = vld_s1 | vld_s2 | vld_s3 | vld_s4 | vld_s5;

	`CNMP_ASSERT(a_barrett_bound, vld_s4 |-> (r_s4 < cnmp_pkg::THREE_PRIME), "remainder above 3P")
	`CNMP_NEVER(a_res_range, vld_s5 && (res_s5 >= cnmp_pkg::PRIME), "result not reduced")

endmodule

// ----- src/cnmp_dp.sv -----
// ---------------------------------------------------------------------------
// Catalan datapath
// Count and index registers, partial-product ring, value registers,
// operand selection, multiplier writeback and the result word register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cnmp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [cnmp_pkg::COUNT_WIDTH-1:0]   count,
	input  cnmp_pkg::cmd_t                     cmd,
	output cnmp_pkg::sts_t                     sts,
	output logic [cnmp_pkg::VAL_W-1:0]         catalan,
	output logic                               catalan_valid,
	input  logic                               catalan_stall
);

	logic [cnmp_pkg::COUNT_WIDTH-1:0] n_q;
	logic [cnmp_pkg::IDX_W-1:0]       idx_q;
	logic [cnmp_pkg::VAL_W-1:0]       ring_q [cnmp_pkg::RING_DEPTH];
	logic [cnmp_pkg::VAL_W-1:0]       acc_q, x1_q, fn1_q, f_q, base_q, catalan_q;
	logic                             out_valid_q;

	logic [cnmp_pkg::IDX_W-1:0]       lo_val, hi_val;
	logic [cnmp_pkg::RED_W-1:0]       idx_ext, idx_red;
	logic [cnmp_pkg::VAL_W-1:0]       np1, ring_rd, op_a, op_b;
	logic                             wb_vld, mul_busy;
	logic [cnmp_pkg::VAL_W-1:0]       wb_val;
	cnmp_pkg::tag_t                   wb_tag, iss_tag;

	assign np1     = cnmp_pkg::VAL_W'({1'b0, n_q} + cnmp_pkg::IDX_W'(1));
	assign ring_rd = ring_q[cmd.slot];
	assign idx_ext = cnmp_pkg::RED_W'(idx_q);
	assign idx_red = (idx_ext >= cnmp_pkg::PRIME_RED) ? idx_ext - cnmp_pkg::PRIME_RED : idx_ext;

	always_comb begin
		case (cmd.lo_sel)
			cnmp_pkg::LO_NP2: lo_val = {1'b0, n_q} + cnmp_pkg::IDX_W'(2);
			default:          lo_val = cnmp_pkg::IDX_W'(2);
		endcase
		case (cmd.hi_sel)
			cnmp_pkg::HI_2N: hi_val = {n_q, 1'b0};
			default:         hi_val = {1'b0, n_q};
		endcase
	end

	always_comb begin
		case (cmd.a_sel)
			cnmp_pkg::A_ONE:  op_a = cnmp_pkg::VAL_W'(1);
			cnmp_pkg::A_RING: op_a = ring_rd;
			cnmp_pkg::A_ACC:  op_a = acc_q;
			cnmp_pkg::A_FN1:  op_a = fn1_q;
			cnmp_pkg::A_BASE: op_a = base_q;
			default:          op_a = '0;
		endcase
		case (cmd.b_sel)
			cnmp_pkg::B_IDX:  op_b = idx_red[cnmp_pkg::VAL_W-1:0];
			cnmp_pkg::B_NP1:  op_b = np1;
			cnmp_pkg::B_RING: op_b = ring_rd;
			cnmp_pkg::B_ACC:  op_b = acc_q;
			cnmp_pkg::B_X1:   op_b = x1_q;
			cnmp_pkg::B_BASE: op_b = base_q;
			cnmp_pkg::B_F:    op_b = f_q;
			default:          op_b = '0;
		endcase
	end

	assign iss_tag.dest = cmd.dest;
	assign iss_tag.slot = cmd.slot;

	cnmp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cmd.issue),
		.a       (op_a),
		.b       (op_b),
		.in_tag  (iss_tag),
		.out_vld (wb_vld),
		.out_val (wb_val),
		.out_tag (wb_tag),
		.busy    (mul_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_count) begin
			n_q <= count;
		end
		if (cmd.stream_start) begin
			idx_q <= lo_val;
			for (int i = 0; i < cnmp_pkg::RING_DEPTH; i++) begin
				ring_q[i] <= cnmp_pkg::VAL_W'(1);
			end
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + cnmp_pkg::IDX_W'(1);
		end
		if (cmd.x1_load) begin
			x1_q <= acc_q;
		end
		if (wb_vld) begin
			case (wb_tag.dest)
				cnmp_pkg::D_RING: ring_q[wb_tag.slot] <= wb_val;
				cnmp_pkg::D_ACC:  acc_q <= wb_val;
				cnmp_pkg::D_FN1:  fn1_q <= wb_val;
				cnmp_pkg::D_F:    f_q <= wb_val;
				cnmp_pkg::D_BASE: base_q <= wb_val;
				cnmp_pkg::D_OUT:  catalan_q <= wb_val;
				default: ;
			endcase
		end
		if (cmd.acc_init) begin
			acc_q <= cnmp_pkg::VAL_W'(1);
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_vld && wb_tag.dest == cnmp_pkg::D_OUT) begin
			out_valid_q <= 1'b1;
		end else if (!catalan_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.idx_le_hi  = (idx_q <= hi_val);
	assign sts.pipe_empty = !mul_busy;
	assign sts.out_busy   = out_valid_q;

	assign catalan       = catalan_q;
	assign catalan_valid = out_valid_q;

	`CNMP_ASSERT(a_out_no_overwrite, (wb_vld && wb_tag.dest == cnmp_pkg::D_OUT) |-> !out_valid_q, "result word overwritten")
	`CNMP_ASSERT(a_ring_wr_slot, (wb_vld && wb_tag.dest == cnmp_pkg::D_RING) |-> (32'(wb_tag.slot) < cnmp_pkg::RING_DEPTH), "ring write slot out of range")
	`CNMP_ASSERT(a_ring_rd_slot, (cmd.issue && (cmd.a_sel == cnmp_pkg::A_RING || cmd.b_sel == cnmp_pkg::B_RING)) |-> (32'(cmd.slot) < cnmp_pkg::RING_DEPTH), "ring read slot out of range")

endmodule

// ----- src/cnmp_ctrl.sv -----
// ---------------------------------------------------------------------------
// Catalan controller
// Sequences the factorial streams, partial-product combine, Fermat
// inversion and final multiply over the shared modular multiplier.
// ---------------------------------------------------------------------------
module cnmp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  count_valid,
	output logic                  count_stall,
	output cnmp_pkg::cmd_t        cmd,
	input  cnmp_pkg::sts_t        sts
);

	cnmp_pkg::state_t               state_q, state_d, ret_q, ret_d;
	cnmp_pkg::phase_t               phase_q, phase_d;
	logic [cnmp_pkg::SLOT_W-1:0]    slot_q, slot_d, slot_adv;
	logic [cnmp_pkg::BIT_W-1:0]     bit_q, bit_d;
	logic                           slot_last;

	assign slot_last = (slot_q == cnmp_pkg::SLOT_W'(cnmp_pkg::RING_DEPTH - 1));
	assign slot_adv  = slot_last ? '0 : slot_q + cnmp_pkg::SLOT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cnmp_pkg::ST_IDLE;
			ret_q   <= cnmp_pkg::ST_IDLE;
			phase_q <= cnmp_pkg::PH_LOW;
			slot_q  <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			phase_q <= phase_d;
			slot_q  <= slot_d;
			bit_q   <= bit_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		phase_d = phase_q;
		slot_d  = slot_q;
		bit_d   = bit_q;

		cmd.load_count   = 1'b0;
		cmd.stream_start = 1'b0;
		cmd.lo_sel       = (phase_q == cnmp_pkg::PH_LOW) ? cnmp_pkg::LO_TWO : cnmp_pkg::LO_NP2;
		cmd.hi_sel       = (phase_q == cnmp_pkg::PH_LOW) ? cnmp_pkg::HI_N : cnmp_pkg::HI_2N;
		cmd.idx_inc      = 1'b0;
		cmd.issue        = 1'b0;
		cmd.a_sel        = cnmp_pkg::A_ONE;
		cmd.b_sel        = cnmp_pkg::B_IDX;
		cmd.dest         = cnmp_pkg::D_ACC;
		cmd.slot         = slot_q;
		cmd.x1_load      = 1'b0;
		cmd.acc_init     = 1'b0;

		count_stall = (state_q != cnmp_pkg::ST_IDLE);

		unique case (state_q)
			cnmp_pkg::ST_IDLE: begin
				if (count_valid) begin
					cmd.load_count = 1'b1;
					phase_d        = cnmp_pkg::PH_LOW;
					state_d        = cnmp_pkg::ST_SETUP;
				end
			end
			cnmp_pkg::ST_SETUP: begin
				cmd.stream_start = 1'b1;
				slot_d           = '0;
				state_d          = cnmp_pkg::ST_STREAM;
			end
			cnmp_pkg::ST_STREAM: begin
				if (sts.idx_le_hi) begin
					cmd.issue   = 1'b1;
					cmd.a_sel   = cnmp_pkg::A_RING;
					cmd.b_sel   = cnmp_pkg::B_IDX;
					cmd.dest    = cnmp_pkg::D_RING;
					cmd.idx_inc = 1'b1;
					slot_d      = slot_adv;
				end else begin
					slot_d  = '0;
					ret_d   = cnmp_pkg::ST_COMBINE;
					state_d = cnmp_pkg::ST_WAIT;
				end
			end
			cnmp_pkg::ST_COMBINE: begin
				cmd.issue = 1'b1;
				cmd.a_sel = (slot_q == '0) ? cnmp_pkg::A_ONE : cnmp_pkg::A_ACC;
				cmd.b_sel = cnmp_pkg::B_RING;
				cmd.dest  = cnmp_pkg::D_ACC;
				slot_d    = slot_adv;
				if (slot_last) begin
					ret_d = (phase_q == cnmp_pkg::PH_LOW) ? cnmp_pkg::ST_FN1 : cnmp_pkg::ST_FMUL;
				end else begin
					ret_d = cnmp_pkg::ST_COMBINE;
				end
				state_d = cnmp_pkg::ST_WAIT;
			end
			cnmp_pkg::ST_FN1: begin
				cmd.x1_load = 1'b1;
				cmd.issue   = 1'b1;
				cmd.a_sel   = cnmp_pkg::A_ACC;
				cmd.b_sel   = cnmp_pkg::B_NP1;
				cmd.dest    = cnmp_pkg::D_FN1;
				phase_d     = cnmp_pkg::PH_HIGH;
				ret_d       = cnmp_pkg::ST_SETUP;
				state_d     = cnmp_pkg::ST_WAIT;
			end
			cnmp_pkg::ST_FMUL: begin
				cmd.issue = 1'b1;
				cmd.a_sel = cnmp_pkg::A_FN1;
				cmd.b_sel = cnmp_pkg::B_ACC;
				cmd.dest  = cnmp_pkg::D_F;
				state_d   = cnmp_pkg::ST_DMUL;
			end
			cnmp_pkg::ST_DMUL: begin
				cmd.issue    = 1'b1;
				cmd.a_sel    = cnmp_pkg::A_FN1;
				cmd.b_sel    = cnmp_pkg::B_X1;
				cmd.dest     = cnmp_pkg::D_BASE;
				cmd.acc_init = 1'b1;
				bit_d        = '0;
				ret_d        = cnmp_pkg::ST_POW_MUL;
				state_d      = cnmp_pkg::ST_WAIT;
			end
			cnmp_pkg::ST_POW_MUL: begin
				if (cnmp_pkg::EXP_VAL[bit_q]) begin
					cmd.issue = 1'b1;
					cmd.a_sel = cnmp_pkg::A_ACC;
					cmd.b_sel = cnmp_pkg::B_BASE;
					cmd.dest  = cnmp_pkg::D_ACC;
				end
				state_d = cnmp_pkg::ST_POW_SQ;
			end
			cnmp_pkg::ST_POW_SQ: begin
				cmd.issue = 1'b1;
				cmd.a_sel = cnmp_pkg::A_BASE;
				cmd.b_sel = cnmp_pkg::B_BASE;
				cmd.dest  = cnmp_pkg::D_BASE;
				if (bit_q == cnmp_pkg::BIT_W'(cnmp_pkg::EXP_BITS - 1)) begin
					ret_d = cnmp_pkg::ST_FINAL;
				end else begin
					bit_d = bit_q + cnmp_pkg::BIT_W'(1);
					ret_d = cnmp_pkg::ST_POW_MUL;
				end
				state_d = cnmp_pkg::ST_WAIT;
			end
			cnmp_pkg::ST_FINAL: begin
				if (!sts.out_busy) begin
					cmd.issue = 1'b1;
					cmd.a_sel = cnmp_pkg::A_ACC;
					cmd.b_sel = cnmp_pkg::B_F;
					cmd.dest  = cnmp_pkg::D_OUT;
					state_d   = cnmp_pkg::ST_IDLE;
				end
			end
			cnmp_pkg::ST_WAIT: begin
				if (sts.pipe_empty) begin
					state_d = ret_q;
				end
			end
			default: begin
				state_d = cnmp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/catalan_number_mod_prime.sv -----
// Throughput: one count at a time; the next count is taken once the final multiply issues.
// The five-stage modular multiplier sets the time: one factorial step per cycle over six
// interleaved partial products, then 30 dependent square-and-multiply rounds.
// Reset returns the controller to idle and drops any pending result word.
// ---------------------------------------------------------------------------
// Catalan number modulo prime
// Returns C(n) mod 1000000009 for each count word, using a controller and
// a datapath built around one pipelined Barrett modular multiplier.
// ---------------------------------------------------------------------------
module catalan_number_mod_prime (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [cnmp_pkg::COUNT_WIDTH-1:0]   count,
	input  logic                               count_valid,
	output logic                               count_stall,
	output logic [cnmp_pkg::VAL_W-1:0]         catalan,
	output logic                               catalan_valid,
	input  logic                               catalan_stall
);

	cnmp_pkg::cmd_t cmd;
	cnmp_pkg::sts_t sts;

	cnmp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.count_valid (count_valid),
		.count_stall (count_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	cnmp_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.count         (count),
		.cmd           (cmd),
		.sts           (sts),
		.catalan       (catalan),
		.catalan_valid (catalan_valid),
		.catalan_stall (catalan_stall)
	);

endmodule
